// File: hw/rtl/rbk_pkg.sv
// Shared types and constants for the receptor binding kinetics evaluator.
// Used by every module of the block; depends on nothing.
`default_nettype none

package rbk_pkg;

  localparam logic [16:0] ONE_Q16    = 17'd65536;
  localparam logic [31:0] LN2_Q32    = 32'hB17217F8;
  localparam logic [47:0] AMOUNT_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic [76:0] PROD_CAP   = 77'd1 << 45;
  localparam logic [37:0] X_CAP      = 38'd1 << 37;
  localparam logic [5:0]  EXP_N_MAX  = 6'd40;
  localparam int          EXP_TERMS  = 14;

  // Configuration register indexes
  localparam logic [2:0] CFG_KON_RATE  = 3'd0;
  localparam logic [2:0] CFG_KOFF_RATE = 3'd1;
  localparam logic [2:0] CFG_RECEPTOR  = 3'd2;
  localparam logic [2:0] CFG_VOLUME    = 3'd3;
  localparam logic [2:0] CFG_THRESHOLD = 3'd4;

  typedef struct packed {
    logic [7:0]  request_tag;
    logic [31:0] ligand_conc;
    logic [31:0] observe_time;
    logic [16:0] start_frac;
  } rbk_in_t;

  typedef struct packed {
    logic [7:0]  tag_out;
    logic [47:0] total_out;
    logic [47:0] bound_out;
    logic [47:0] free_out;
    logic [16:0] equilibrium_frac;
    logic [16:0] final_frac;
    logic        crossed;
    logic [31:0] cross_time;
  } rbk_out_t;

  typedef struct packed {
    logic [31:0] kon;
    logic [31:0] koff;
    logic [31:0] rconc;
    logic [19:0] vol;
    logic [16:0] thr;
  } rbk_cfg_t;

  // Per-item context carried down the pipeline
  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] t;
    logic [16:0] f0;
    logic [16:0] thr;
    logic [55:0] a;
    logic [56:0] r;
    logic [37:0] x;
    logic [47:0] total;
    logic [16:0] eq;
    logic [32:0] e;
    logic [16:0] fin;
    logic [47:0] bound;
    logic [47:0] free;
    logic [36:0] lden;
    logic [36:0] lnum;
    logic [45:0] num;
  } ctx_t;

  // floor(2^34 / k) for the Taylor term divisors
  function automatic logic [34:0] recip_q34(input int unsigned k);
    case (k)
      1:       return 35'd17179869184;
      2:       return 35'd8589934592;
      3:       return 35'd5726623061;
      4:       return 35'd4294967296;
      5:       return 35'd3435973836;
      6:       return 35'd2863311530;
      7:       return 35'd2454267026;
      8:       return 35'd2147483648;
      9:       return 35'd1908874353;
      10:      return 35'd1717986918;
      11:      return 35'd1561806289;
      12:      return 35'd1431655765;
      13:      return 35'd1321528398;
      14:      return 35'd1227133513;
      default: return 35'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rbk_front.sv
// Front stages: rate products, combined rate, total amount and exponent.
// Depends on rbk_pkg.
`default_nettype none

module rbk_front import rbk_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     en,
  input  logic     in_valid,
  input  rbk_in_t  in_data,
  input  rbk_cfg_t cfg,
  output logic     out_valid,
  output ctx_t     out_ctx
);

  logic        v1, v2, v3, v4;
  ctx_t        c1, c2, c3, c4;
  ctx_t        c1_next, c2_next, c4_next;
  logic [63:0] kl1;
  logic [51:0] tot1;
  logic [53:0] phi3;
  logic [54:0] plo3;
  logic        big3;
  logic [76:0] p4;

  // Saturate fractions, start the products
  always_comb begin
    c1_next     = '0;
    c1_next.tag = in_data.request_tag;
    c1_next.t   = in_data.observe_time;
    c1_next.f0  = (in_data.start_frac > ONE_Q16) ? ONE_Q16 : in_data.start_frac;
    c1_next.thr = (cfg.thr > ONE_Q16) ? ONE_Q16 : cfg.thr;
  end

  // Combined rate and saturated total
  always_comb begin
    c2_next       = c1;
    c2_next.a     = kl1[63:8];
    c2_next.r     = {1'b0, kl1[63:8]} + {17'd0, cfg.koff, 8'd0};
    c2_next.total = (tot1 > 52'(AMOUNT_MAX)) ? AMOUNT_MAX : tot1[47:0];
  end

  // Merge partial products and saturate the exponent
  always_comb begin
    p4        = (77'(phi3) << 23) + 77'(plo3);
    c4_next   = c3;
    c4_next.x = (big3 || p4 > PROD_CAP) ? X_CAP : p4[45:8];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c1   <= c1_next;
      kl1  <= 64'(in_data.ligand_conc) * 64'(cfg.kon);
      tot1 <= 52'(cfg.rconc) * 52'(cfg.vol);
      c2   <= c2_next;
      c3   <= c2;
      phi3 <= 54'(c2.r[44:23]) * 54'(c2.t);
      plo3 <= 55'(c2.r[22:0]) * 55'(c2.t);
      big3 <= (c2.r[56:45] != 12'd0) && (c2.t != 32'd0);
      c4   <= c4_next;
    end
  end

  assign out_valid = v4;
  assign out_ctx   = c4;

endmodule

`default_nettype wire

// File: hw/rtl/rbk_div.sv
// Pipelined restoring divider, one quotient bit per stage, context alongside.
// Depends on rbk_pkg.
`default_nettype none

module rbk_div import rbk_pkg::*; #(
  parameter int QW = 16,
  parameter int DW = 57
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  ctx_t          in_ctx,
  input  logic [DW-1:0] rem0,
  input  logic [QW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          out_valid,
  output ctx_t          out_ctx,
  output logic [QW-1:0] quo
);

  localparam int RW = DW + 1;

  logic          v_r   [0:QW-1];
  ctx_t          ctx_r [0:QW-1];
  logic [DW-1:0] rem_r [0:QW-1];
  logic [DW-1:0] den_r [0:QW-1];
  logic [QW-1:0] num_r [0:QW-1];
  logic [QW-1:0] q_r   [0:QW-1];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic          v_p;
    ctx_t          ctx_p;
    logic [DW-1:0] rem_p, den_p;
    logic [QW-1:0] num_p, q_p;
    logic [RW-1:0] sh, diff;
    logic          ge;

    if (s == 0) begin : g_first
      assign v_p   = in_valid;
      assign ctx_p = in_ctx;
      assign rem_p = rem0;
      assign den_p = den;
      assign num_p = num;
      assign q_p   = '0;
    end else begin : g_rest
      assign v_p   = v_r[s-1];
      assign ctx_p = ctx_r[s-1];
      assign rem_p = rem_r[s-1];
      assign den_p = den_r[s-1];
      assign num_p = num_r[s-1];
      assign q_p   = q_r[s-1];
    end

    // Shift in the next numerator bit and try the subtract
    assign sh   = {rem_p, num_p[QW-1]};
    assign diff = sh - {1'b0, den_p};
    assign ge   = (sh >= {1'b0, den_p});

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[s] <= 1'b0;
      end else if (en) begin
        v_r[s] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ctx_r[s] <= ctx_p;
        rem_r[s] <= ge ? diff[DW-1:0] : sh[DW-1:0];
        den_r[s] <= den_p;
        num_r[s] <= num_p << 1;
        q_r[s]   <= {q_p[QW-2:0], ge};
      end
    end
  end

  assign out_valid = v_r[QW-1];
  assign out_ctx   = ctx_r[QW-1];
  assign quo       = q_r[QW-1];

endmodule

`default_nettype wire

// File: hw/rtl/rbk_exp.sv
// Pipelined exp(-x) in Q1.32: ln2 range reduction, Taylor series, final shift.
// Depends on rbk_pkg.
`default_nettype none

module rbk_exp import rbk_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  ctx_t in_ctx,
  output logic out_valid,
  output ctx_t out_ctx
);

  typedef struct packed {
    logic [32:0] term;
    logic [33:0] pos;
    logic [33:0] neg;
    logic [31:0] s;
    logic [5:0]  n;
    ctx_t        ctx;
  } tay_t;

  logic        n1_v;
  ctx_t        n1_ctx;
  logic [37:0] n1_rem, n1_rem_next, ra, rb;
  logic [2:0]  n1_n, n1_n_next, n2_n_next;
  tay_t        ent   [0:EXP_TERMS];
  logic        ent_v [0:EXP_TERMS];
  tay_t        ent0_next;
  logic        fo_v;
  ctx_t        fo_ctx, fo_ctx_next;
  logic [33:0] diff;

  // Upper three quotient bits of x / ln2
  always_comb begin
    ra        = in_ctx.x;
    n1_n_next = '0;
    for (int i = 0; i < 3; i++) begin
      if (ra >= (38'(LN2_Q32) << (5 - i))) begin
        ra               = ra - (38'(LN2_Q32) << (5 - i));
        n1_n_next[2 - i] = 1'b1;
      end
    end
    n1_rem_next = ra;
  end

  // Lower three bits, then seed the series
  always_comb begin
    rb        = n1_rem;
    n2_n_next = '0;
    for (int i = 0; i < 3; i++) begin
      if (rb >= (38'(LN2_Q32) << (2 - i))) begin
        rb               = rb - (38'(LN2_Q32) << (2 - i));
        n2_n_next[2 - i] = 1'b1;
      end
    end
    ent0_next.term = 33'd1 << 32;
    ent0_next.pos  = 34'd1 << 32;
    ent0_next.neg  = '0;
    ent0_next.s    = rb[31:0];
    ent0_next.n    = {n1_n, n2_n_next};
    ent0_next.ctx  = n1_ctx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n1_v     <= 1'b0;
      ent_v[0] <= 1'b0;
    end else if (en) begin
      n1_v     <= in_valid;
      ent_v[0] <= n1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n1_ctx <= in_ctx;
      n1_rem <= n1_rem_next;
      n1_n   <= n1_n_next;
      ent[0] <= ent0_next;
    end
  end

  // One Taylor term per three stages: multiply, reciprocal, correct
  for (genvar j = 0; j < EXP_TERMS; j++) begin : g_term
    localparam int unsigned K = j + 1;
    logic        a_v, b_v;
    tay_t        a_ent, b_ent, c_next;
    logic [31:0] a_val, b_val, q_est, q_fix;
    logic [66:0] b_qp;
    logic [64:0] prod;
    logic [35:0] rem;

    assign prod  = 65'(ent[j].term) * 65'(ent[j].s);
    assign q_est = b_qp[65:34];
    assign rem   = 36'(b_val) - 36'(q_est) * 36'(K);
    assign q_fix = (rem >= 36'(K)) ? q_est + 32'd1 : q_est;

    always_comb begin
      c_next      = b_ent;
      c_next.term = 33'(q_fix);
      if (K % 2 == 1) begin
        c_next.neg = b_ent.neg + 34'(q_fix);
      end else begin
        c_next.pos = b_ent.pos + 34'(q_fix);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        a_v        <= 1'b0;
        b_v        <= 1'b0;
        ent_v[j+1] <= 1'b0;
      end else if (en) begin
        a_v        <= ent_v[j];
        b_v        <= a_v;
        ent_v[j+1] <= b_v;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_ent    <= ent[j];
        a_val    <= prod[63:32];
        b_ent    <= a_ent;
        b_val    <= a_val;
        b_qp     <= 67'(a_val) * 67'(recip_q34(K));
        ent[j+1] <= c_next;
      end
    end
  end

  // Combine the sums and apply the power of two
  always_comb begin
    diff          = ent[EXP_TERMS].pos - ent[EXP_TERMS].neg;
    fo_ctx_next   = ent[EXP_TERMS].ctx;
    if (ent[EXP_TERMS].n >= EXP_N_MAX || ent[EXP_TERMS].pos < ent[EXP_TERMS].neg) begin
      fo_ctx_next.e = '0;
    end else begin
      fo_ctx_next.e = 33'(diff >> ent[EXP_TERMS].n);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fo_v <= 1'b0;
    end else if (en) begin
      fo_v <= ent_v[EXP_TERMS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fo_ctx <= fo_ctx_next;
    end
  end

  assign out_valid = fo_v;
  assign out_ctx   = fo_ctx;

endmodule

`default_nettype wire

// File: hw/rtl/rbk_log2.sv
// Two-lane pipelined log2 in Q.32 by repeated squaring of the mantissa.
// Lanes take eq - f0 and eq - threshold. Depends on rbk_pkg.
`default_nettype none

module rbk_log2 import rbk_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  ctx_t in_ctx,
  output logic out_valid,
  output ctx_t out_ctx
);

  localparam int STEPS = 32;

  typedef struct packed {
    logic [1:0][31:0] y;
    logic [1:0][4:0]  p;
    logic [1:0][31:0] frac;
    ctx_t             ctx;
  } lg_t;

  lg_t         st   [0:STEPS];
  logic        st_v [0:STEPS];
  lg_t         st0_next;
  logic [16:0] lv [2];

  // Find the leading one and normalize to Q1.31
  always_comb begin
    lv[0]        = in_ctx.eq - in_ctx.f0;
    lv[1]        = in_ctx.eq - in_ctx.thr;
    st0_next.ctx = in_ctx;
    for (int l = 0; l < 2; l++) begin
      st0_next.p[l] = '0;
      for (int i = 1; i < 17; i++) begin
        if (lv[l][i]) begin
          st0_next.p[l] = 5'(i);
        end
      end
      st0_next.y[l]    = 32'(lv[l]) << (5'd31 - st0_next.p[l]);
      st0_next.frac[l] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_v[0] <= 1'b0;
    end else if (en) begin
      st_v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st[0] <= st0_next;
    end
  end

  // Square, renormalize, emit one fraction bit per lane
  for (genvar k = 0; k < STEPS; k++) begin : g_sq
    lg_t         nxt;
    logic [63:0] sq [2];

    always_comb begin
      nxt = st[k];
      for (int l = 0; l < 2; l++) begin
        sq[l] = 64'(st[k].y[l]) * 64'(st[k].y[l]);
        if (sq[l][63]) begin
          nxt.y[l]    = sq[l][63:32];
          nxt.frac[l] = {st[k].frac[l][30:0], 1'b1};
        end else begin
          nxt.y[l]    = sq[l][62:31];
          nxt.frac[l] = {st[k].frac[l][30:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_v[k+1] <= 1'b0;
      end else if (en) begin
        st_v[k+1] <= st_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  always_comb begin
    out_ctx      = st[STEPS].ctx;
    out_ctx.lden = {st[STEPS].p[0], st[STEPS].frac[0]};
    out_ctx.lnum = {st[STEPS].p[1], st[STEPS].frac[1]};
  end

  assign out_valid = st_v[STEPS];

endmodule

`default_nettype wire

// File: hw/rtl/receptor_binding_kinetics_eval_top.sv
// Receptor binding kinetics evaluator, fully pipelined.
// Takes one request per cycle while no result stall holds the pipeline.
// The pipeline is built from 16-step and 46-step dividers, a 45-stage exp, a 33-stage log2
// and the front and finishing stages. Any result stall holds all stages.
// Reset clears all valid bits and loads the configuration register defaults.
`default_nettype none

module receptor_binding_kinetics_eval_top import rbk_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_ready,
  input  rbk_in_t     req_data,
  output logic        res_valid,
  input  logic        res_ready,
  output rbk_out_t    res_data,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  rbk_cfg_t    cfg;
  logic        en;
  logic        fr_v, de_v, t1_v, ex_v, t2_v, t3_v, t4_v, lg_v, t5_v, t6_v, dc_v;
  ctx_t        fr_c, de_c, t1_c, ex_c, t2_c, t3_c, t4_c, lg_c, t5_c, t6_c, dc_c;
  ctx_t        t1_next, t3_next, t4_next, t5_next, t6_next;
  logic [15:0] de_q;
  logic [45:0] dc_q;
  logic [49:0] t2_prod;
  logic        t2_neg;
  logic [16:0] mag;
  logic [50:0] rnd;
  logic [18:0] adj;
  logic [19:0] fin_w;
  logic [64:0] bp;
  logic [36:0] dd;
  logic [63:0] t5_pf;
  logic [37:0] t5_pi, ln;
  logic        early, try_cross;
  rbk_out_t    res_next;

  // Whole pipeline advances unless a result is held
  assign en        = !res_valid || res_ready;
  assign req_ready = en;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.kon   <= 32'd65536;
      cfg.koff  <= 32'd0;
      cfg.rconc <= 32'd65536;
      cfg.vol   <= 20'd1000;
      cfg.thr   <= 17'd32768;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_KON_RATE:  cfg.kon   <= cfg_data;
        CFG_KOFF_RATE: cfg.koff  <= cfg_data;
        CFG_RECEPTOR:  cfg.rconc <= cfg_data;
        CFG_VOLUME:    cfg.vol   <= cfg_data[19:0];
        CFG_THRESHOLD: cfg.thr   <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  rbk_front u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(req_valid && req_ready), .in_data(req_data), .cfg(cfg),
    .out_valid(fr_v), .out_ctx(fr_c)
  );

  rbk_div #(.QW(16), .DW(57)) u_div_eq (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(fr_v), .in_ctx(fr_c),
    .rem0({1'b0, fr_c.a}), .num(16'd0), .den(fr_c.r),
    .out_valid(de_v), .out_ctx(de_c), .quo(de_q)
  );

  // Pick the equilibrium: start fraction for zero rate, one for full binding, else the quotient
  always_comb begin
    t1_next = de_c;
    if (de_c.r == 57'd0) begin
      t1_next.eq = de_c.f0;
    end else if ({1'b0, de_c.a} >= de_c.r) begin
      t1_next.eq = ONE_Q16;
    end else begin
      t1_next.eq = {1'b0, de_q};
    end
  end

  rbk_exp u_exp (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(t1_v), .in_ctx(t1_c),
    .out_valid(ex_v), .out_ctx(ex_c)
  );

  // Scale the distance to equilibrium by the decay
  assign mag = (ex_c.f0 >= ex_c.eq) ? ex_c.f0 - ex_c.eq : ex_c.eq - ex_c.f0;

  // Round the adjustment, relax toward equilibrium, clamp
  always_comb begin
    rnd     = 51'(t2_prod) + (51'd1 << 31);
    adj     = rnd[50:32];
    t3_next = t2_c;
    if (!t2_neg) begin
      fin_w = 20'(t2_c.eq) + 20'(adj);
    end else if (adj > 19'(t2_c.eq)) begin
      fin_w = '0;
    end else begin
      fin_w = 20'(t2_c.eq) - 20'(adj);
    end
    t3_next.fin = (fin_w > 20'(ONE_Q16)) ? ONE_Q16 : fin_w[16:0];
  end

  assign bp = 65'(t3_c.total) * 65'(t3_c.fin) + 65'd32768;

  // Attach the rounded bound amount
  always_comb begin
    t4_next       = t3_c;
    t4_next.bound = bp[63:16];
  end

  rbk_log2 u_log2 (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(t4_v), .in_ctx(t4_c),
    .out_valid(lg_v), .out_ctx(lg_c)
  );

  // Attach the free amount
  always_comb begin
    t5_next      = lg_c;
    t5_next.free = lg_c.total - lg_c.bound;
  end

  // Log ratio in base two, then to natural log
  assign dd = (lg_c.lden > lg_c.lnum) ? lg_c.lden - lg_c.lnum : 37'd0;
  assign ln = t5_pi + 38'(t5_pf[63:32]);

  always_comb begin
    t6_next     = t5_c;
    t6_next.num = {ln, 8'd0};
  end

  rbk_div #(.QW(46), .DW(57)) u_div_ct (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(t6_v), .in_ctx(t6_c),
    .rem0(57'd0), .num(t6_c.num), .den(t6_c.r),
    .out_valid(dc_v), .out_ctx(dc_c), .quo(dc_q)
  );

  // Decide the crossing and build the result
  always_comb begin
    early                     = (dc_c.f0 >= dc_c.thr);
    try_cross                 = (dc_c.r != 57'd0) && (dc_c.eq > dc_c.thr);
    res_next.tag_out          = dc_c.tag;
    res_next.total_out        = dc_c.total;
    res_next.bound_out        = dc_c.bound;
    res_next.free_out         = dc_c.free;
    res_next.equilibrium_frac = dc_c.eq;
    res_next.final_frac       = dc_c.fin;
    res_next.crossed          = 1'b0;
    res_next.cross_time       = '0;
    if (early) begin
      res_next.crossed = 1'b1;
    end else if (try_cross && dc_q <= 46'(dc_c.t)) begin
      res_next.crossed    = 1'b1;
      res_next.cross_time = dc_q[31:0];
    end
  end

  // Advance valid bits of the local stages
  always_ff @(posedge clk) begin
    if (rst) begin
      t1_v      <= 1'b0;
      t2_v      <= 1'b0;
      t3_v      <= 1'b0;
      t4_v      <= 1'b0;
      t5_v      <= 1'b0;
      t6_v      <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      t1_v      <= de_v;
      t2_v      <= ex_v;
      t3_v      <= t2_v;
      t4_v      <= t3_v;
      t5_v      <= lg_v;
      t6_v      <= t5_v;
      res_valid <= dc_v;
    end
  end

  // Advance payload of the local stages
  always_ff @(posedge clk) begin
    if (en) begin
      t1_c     <= t1_next;
      t2_c     <= ex_c;
      t2_prod  <= 50'(mag) * 50'(ex_c.e);
      t2_neg   <= (ex_c.f0 < ex_c.eq);
      t3_c     <= t3_next;
      t4_c     <= t4_next;
      t5_c     <= t5_next;
      t5_pf    <= 64'(dd[31:0]) * 64'(LN2_Q32);
      t5_pi    <= 38'(dd[36:32]) * 38'(LN2_Q32);
      t6_c     <= t6_next;
      res_data <= res_next;
    end
  end

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |-> !req_ready)
    else $error("request taken while result stalled");

  a_cross_time: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.crossed || res_data.cross_time == 32'd0))
    else $error("cross time set without crossing");

  a_amount_sum: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (49'(res_data.bound_out) + 49'(res_data.free_out)
                   == 49'(res_data.total_out)))
    else $error("bound plus free differs from total");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res_data.final_frac <= ONE_Q16 && res_data.equilibrium_frac <= ONE_Q16))
    else $error("fraction above one");

endmodule

`default_nettype wire

// File: dv/receptor_binding_kinetics_eval_top_test.sv
// Self-checking bench for the receptor binding kinetics evaluator.
// Depends on rbk_pkg and receptor_binding_kinetics_eval_top; predicts every result in fixed point.
module receptor_binding_kinetics_eval_top_test;
  import rbk_pkg::*;

  localparam int PIPE_DEPTH = 151;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int LONG_HOLD = 400;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  rbk_in_t     req_data = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  rbk_out_t    res_data;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Predictor copy of the registers
  bit [63:0] kon_q16, koff_q16, rconc_q16, vol_fl, thr_q16;

  rbk_in_t  pending_q[$];
  rbk_out_t binding_expect_q[$];
  int       mismatch_count = 0;
  int       cycle_count = 0;
  int       send_gap = 0;
  int       hold_left = 0;
  bit       calm = 1'b0;
  bit       long_hold_req = 1'b0;
  bit       long_hold_done = 1'b0;

  receptor_binding_kinetics_eval_top DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Abort on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // log2 of v in Q.32: integer part from the msb, fraction by repeated squaring
  function automatic bit [63:0] log2_fix(bit [63:0] v);
    int unsigned p;
    bit [63:0]   y;
    bit [63:0]   frac;
    p = 0;
    frac = 0;
    while (p < 31 && (v >> (p + 1)) != 0) p++;
    y = v << (31 - p);
    for (int i = 0; i < 32; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= 64'h1_0000_0000) begin
        y = y >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(p) << 32) | 64'(frac[31:0]);
  endfunction

  function automatic rbk_out_t binding_predict(rbk_in_t it);
    rbk_out_t  o;
    bit [63:0] t, f0, thr, a, r, eq, x, e, mag, adj, fin, total, bound;
    bit [63:0] rem, q, p, n, s, pos, neg, term, lden, lnum, d, ln, ct;
    t = 64'(it.observe_time);
    f0 = 64'(it.start_frac);
    thr = thr_q16;
    if (f0 > 65536) f0 = 64'd65536;
    if (thr > 65536) thr = 64'd65536;
    a = (kon_q16 * 64'(it.ligand_conc)) >> 8;
    r = a + (koff_q16 << 8);
    // equilibrium by restoring division
    if (r == 0) eq = f0;
    else if (a >= r) eq = 64'd65536;
    else begin
      rem = a;
      q = 0;
      for (int i = 0; i < 16; i++) begin
        rem = rem << 1;
        q = q << 1;
        if (rem >= r) begin
          rem = rem - r;
          q = q | 64'd1;
        end
      end
      eq = q;
    end
    // exponent, saturated
    if (t != 0 && r > (64'd1 << 45) / t) x = 64'd1 << 37;
    else begin
      p = r * t;
      if (p > (64'd1 << 45)) p = 64'd1 << 45;
      x = p >> 8;
    end
    // exp(-x): range reduce by ln2, Taylor on remainder
    n = x / 64'(LN2_Q32);
    s = x - n * 64'(LN2_Q32);
    if (n >= 40) e = 0;
    else begin
      pos = 64'h1_0000_0000;
      neg = 0;
      term = 64'h1_0000_0000;
      for (int k = 1; k <= 14; k++) begin
        term = ((term * s) >> 32) / 64'(k);
        if (k % 2 == 1) neg = neg + term;
        else pos = pos + term;
      end
      e = (pos < neg) ? 64'd0 : (pos - neg) >> n;
    end
    if (f0 >= eq) begin
      mag = f0 - eq;
      adj = (mag * e + 64'h8000_0000) >> 32;
      fin = eq + adj;
    end else begin
      mag = eq - f0;
      adj = (mag * e + 64'h8000_0000) >> 32;
      fin = (adj > eq) ? 64'd0 : eq - adj;
    end
    if (fin > 65536) fin = 64'd65536;
    total = rconc_q16 * vol_fl;
    if (total > 64'(AMOUNT_MAX)) total = 64'(AMOUNT_MAX);
    bound = (total * fin + 64'd32768) >> 16;
    o.crossed = 1'b0;
    o.cross_time = '0;
    if (f0 >= thr) begin
      o.crossed = 1'b1;
    end else if (r != 0 && eq > thr) begin
      lden = log2_fix(eq - f0);
      lnum = log2_fix(eq - thr);
      d = (lden > lnum) ? lden - lnum : 64'd0;
      ln = (d >> 32) * 64'(LN2_Q32) + (({32'd0, d[31:0]} * 64'(LN2_Q32)) >> 32);
      ct = (ln << 8) / r;
      if (ct <= t) begin
        o.crossed = 1'b1;
        o.cross_time = ct[31:0];
      end
    end
    o.tag_out = it.request_tag;
    o.total_out = total[47:0];
    o.bound_out = bound[47:0];
    o.free_out = 48'(total - bound);
    o.equilibrium_frac = eq[16:0];
    o.final_frac = fin[16:0];
    return o;
  endfunction

  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Driver: present queued requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_ready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        req_valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        req_data <= pending_q.pop_front();
        req_valid <= 1'b1;
        send_gap <= gap_len();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      long_hold_done <= 1'b1;
      hold_left <= LONG_HOLD;
      res_ready <= 1'b0;
    end else if (calm) begin
      res_ready <= 1'b1;
    end else begin
      hold_left <= gap_len();
      res_ready <= 1'b1;
    end
  end

  // Predict on each request transfer
  always @(posedge clk) begin
    if (!rst && req_valid && req_ready) binding_expect_q.push_back(binding_predict(req_data));
  end

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Compare each result transfer with the oldest prediction
  always @(posedge clk) begin
    rbk_out_t want;
    if (!rst && res_valid && res_ready) begin
      if (binding_expect_q.size() == 0) begin
        $error("result with tag %0d arrived with nothing outstanding", res_data.tag_out);
        mismatch_count++;
      end else begin
        want = binding_expect_q.pop_front();
        check_field("tag_out", 64'(res_data.tag_out), 64'(want.tag_out));
        check_field("total_out", 64'(res_data.total_out), 64'(want.total_out));
        check_field("bound_out", 64'(res_data.bound_out), 64'(want.bound_out));
        check_field("free_out", 64'(res_data.free_out), 64'(want.free_out));
        check_field("equilibrium_frac", 64'(res_data.equilibrium_frac),
                    64'(want.equilibrium_frac));
        check_field("final_frac", 64'(res_data.final_frac), 64'(want.final_frac));
        check_field("crossed", 64'(res_data.crossed), 64'(want.crossed));
        check_field("cross_time", 64'(res_data.cross_time), 64'(want.cross_time));
      end
    end
  end

  task automatic cfg_put(logic [2:0] idx, bit [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_KON_RATE:  kon_q16 = 64'(val);
      CFG_KOFF_RATE: koff_q16 = 64'(val);
      CFG_RECEPTOR:  rconc_q16 = 64'(val);
      CFG_VOLUME:    vol_fl = 64'(val[19:0]);
      CFG_THRESHOLD: thr_q16 = 64'(val[16:0]);
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic cfg_all(bit [31:0] kon, bit [31:0] koff, bit [31:0] rc,
                         bit [19:0] vol, bit [16:0] thr);
    cfg_put(CFG_KON_RATE, kon);
    cfg_put(CFG_KOFF_RATE, koff);
    cfg_put(CFG_RECEPTOR, rc);
    cfg_put(CFG_VOLUME, {12'd0, vol});
    cfg_put(CFG_THRESHOLD, {15'd0, thr});
  endtask

  // Let the pipe drain fully before touching registers
  task automatic drain();
    while (pending_q.size() > 0 || req_valid || binding_expect_q.size() > 0) @(posedge clk);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
  endtask

  function automatic rbk_in_t make_req(bit [31:0] lig, bit [31:0] t, bit [16:0] f0);
    rbk_in_t it;
    it.request_tag = 8'($urandom_range(0, 255));
    it.ligand_conc = lig;
    it.observe_time = t;
    it.start_frac = f0;
    return it;
  endfunction

  // Mostly physically meaningful magnitudes, some full-range noise
  task automatic push_random(int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(0, 3);
      case (mode)
        0: pending_q.push_back(make_req($urandom, $urandom, 17'($urandom_range(0, 131071))));
        1: pending_q.push_back(make_req($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
                                        17'($urandom_range(0, 65536))));
        2: pending_q.push_back(make_req($urandom_range(0, 1 << 17), $urandom_range(0, 1 << 24),
                                        17'($urandom_range(0, 16384))));
        default: pending_q.push_back(make_req($urandom_range(0, 1 << 24),
                                              $urandom_range(0, 1 << 16),
                                              17'($urandom_range(0, 65536))));
      endcase
    end
  endtask

  initial begin
    kon_q16 = 64'd65536;
    koff_q16 = 64'd0;
    rconc_q16 = 64'd65536;
    vol_fl = 64'd1000;
    thr_q16 = 64'd32768;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed corners at reset settings
    calm <= 1'b1;
    pending_q.push_back(make_req(32'd0, 32'd0, 17'd0));
    pending_q.push_back(make_req(32'd0, 32'hFFFF_FFFF, 17'd40000));
    pending_q.push_back(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd0));
    pending_q.push_back(make_req(32'hFFFF_FFFF, 32'd0, 17'd65536));
    pending_q.push_back(make_req(32'd65536, 32'd65536, 17'd0));
    pending_q.push_back(make_req(32'd65536, 32'd655360, 17'd1000));
    pending_q.push_back(make_req(32'd1, 32'd1, 17'h1FFFF));
    pending_q.push_back(make_req(32'd1 << 20, 32'd30000, 17'd32767));
    pending_q.push_back(make_req(32'd1 << 20, 32'd30000, 17'd32768));
    pending_q.push_back(make_req(32'd200, 32'd1 << 24, 17'd100));
    pending_q.push_back(make_req(32'd1 << 18, 32'd1, 17'd0));
    pending_q.push_back(make_req(32'd1 << 18, 32'd1 << 14, 17'd0));
    drain();

    // Low extremes, zero threshold, small totals
    cfg_all(32'd1, 32'd0, 32'd1, 20'd1, 17'd0);
    pending_q.push_back(make_req(32'd0, 32'd100, 17'd0));
    pending_q.push_back(make_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'd5));
    calm <= 1'b0;
    push_random(200);
    drain();

    // High extremes, threshold above one, receiver long hold
    cfg_all(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 20'hFFFFF, 17'h1FFFF);
    pending_q.push_back(make_req(32'd0, 32'd0, 17'd65536));
    calm <= 1'b1;
    long_hold_req <= 1'b1;
    push_random(350);
    drain();
    calm <= 1'b0;

    // Crossing-friendly settings
    cfg_all(32'd65536, 32'd16384, 32'd65536, 20'd1000, 17'd1);
    push_random(300);
    drain();
    cfg_all(32'd1 << 20, 32'd1 << 12, 32'd1 << 24, 20'd50000, 17'd65536);
    push_random(300);
    drain();
    cfg_all(32'd0, 32'd65536, 32'd0, 20'd0, 17'd20000);
    pending_q.push_back(make_req(32'd12345, 32'd65536, 17'd30000));
    push_random(100);
    drain();

    // Random settings
    for (int ph = 0; ph < 3; ph++) begin
      cfg_all($urandom_range(1, 1 << 22), $urandom_range(0, 1 << 18), $urandom,
              20'($urandom_range(1, 20'hFFFFF)), 17'($urandom_range(1, 65536)));
      push_random(230);
      drain();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
